[hdl/modinv_pkg.sv]
// Shared types for the modular inverse block.
package modinv_pkg;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ALIGN = 5'b00010,
    ST_SUB   = 5'b00100,
    ST_NEXT  = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

endpackage

[hdl/modinv_if.sv]
// Request and response channel interfaces of the modular inverse block.
interface modinv_in_if #(
  parameter int WIDTH = 16
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;
  logic [WIDTH-1:0] modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink   (input valid, input value, input modulus, output ready);
endinterface

interface modinv_out_if #(
  parameter int WIDTH = 16
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] inverse;
  logic             has_inverse;

  modport source (output valid, output inverse, output has_inverse, input ready);
  modport sink   (input valid, input inverse, input has_inverse, output ready);
endinterface

[hdl/modinv_macc.sv]
// Modular multiply-accumulate step: result = (2 * acc + bit * addend) mod modulus.
module modinv_macc #(
  parameter int WIDTH = 16
) (
  input  logic [WIDTH-1:0] acc,
  input  logic [WIDTH-1:0] addend,
  input  logic [WIDTH-1:0] modulus,
  input  logic             add_en,
  output logic [WIDTH-1:0] result
);
  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] mod1;
  logic [WIDTH+1:0] mod2;
  logic [WIDTH+1:0] red;

  always_comb begin
    sum  = {1'b0, acc, 1'b0} + (add_en ? {2'b00, addend} : {(WIDTH+2){1'b0}});
    mod1 = {2'b00, modulus};
    mod2 = {1'b0, modulus, 1'b0};
    if (sum >= mod2) begin
      red = sum - mod2;
    end else if (sum >= mod1) begin
      red = sum - mod1;
    end else begin
      red = sum;
    end
    result = red[WIDTH-1:0];
  end

endmodule

[hdl/modular_inverse.sv]
// Modular inverse by the extended Euclidean algorithm on one shared shift-subtract unit.
//
// The block takes one request (value, modulus) at a time and returns the inverse of the value
// modulo the modulus together with a flag that is set when the modulus is at least two and the
// gcd is one; without an inverse both are zero. The work runs on a single shift-and-subtract
// divider whose quotient bits feed a modular multiply-accumulate, so the Bezout coefficient is
// updated as the quotient appears. A division runs as alignment shifts of the divisor, a step
// that ends the alignment, subtract steps that each yield one quotient bit, and one update; the
// first division reduces the value by the modulus, and the rest follow the remainder sequence.
// The idle and finish states take the request and hand over the result. The block accepts a
// new request only while idle, but a finished result may wait in the output register while the
// next request runs.
module modular_inverse #(
  parameter int WIDTH = 16
) (
  input logic                 clk,
  input logic                 rst_n,
  modinv_in_if.sink           in_req,
  modinv_out_if.source        out_rsp
);
  import modinv_pkg::*;

  localparam int CW = $clog2(WIDTH);

  state_t           state_r, state_nxt;
  logic [WIDTH-1:0] num_r, num_nxt;
  logic [WIDTH-1:0] den_r, den_nxt;
  logic [WIDTH-1:0] dsh_r, dsh_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] t0_r, t0_nxt;
  logic [WIDTH-1:0] t1_r, t1_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] mod_r, mod_nxt;
  logic             red_r, red_nxt;
  logic [WIDTH-1:0] res_inv_r, res_inv_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] out_inv_r, out_inv_nxt;
  logic             out_ok_r, out_ok_nxt;

  logic             in_fire;
  logic             out_fire;
  logic             sub_ge;
  logic             align_go;
  logic [WIDTH-1:0] macc_res;
  logic [WIDTH-1:0] t_new;

  assign in_req.ready        = (state_r == ST_IDLE);
  assign in_fire             = in_req.valid && in_req.ready;
  assign out_fire            = out_valid_r && out_rsp.ready;
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.inverse     = out_inv_r;
  assign out_rsp.has_inverse = out_ok_r;

  assign sub_ge   = (num_r >= dsh_r);
  assign align_go = ({1'b0, num_r} >= {dsh_r, 1'b0});
  assign t_new    = t0_r - acc_r + ((t0_r >= acc_r) ? {WIDTH{1'b0}} : mod_r);

  modinv_macc #(
    .WIDTH (WIDTH)
  ) u_macc (
    .acc     (acc_r),
    .addend  (t1_r),
    .modulus (mod_r),
    .add_en  (sub_ge),
    .result  (macc_res)
  );

  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    dsh_nxt       = dsh_r;
    cnt_nxt       = cnt_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    acc_nxt       = acc_r;
    mod_nxt       = mod_r;
    red_nxt       = red_r;
    res_inv_nxt   = res_inv_r;
    res_ok_nxt    = res_ok_r;
    out_valid_nxt = out_valid_r;
    out_inv_nxt   = out_inv_r;
    out_ok_nxt    = out_ok_r;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          mod_nxt = in_req.modulus;
          if (in_req.modulus < WIDTH'(2)) begin
            res_inv_nxt = '0;
            res_ok_nxt  = 1'b0;
            state_nxt   = ST_FIN;
          end else begin
            num_nxt   = in_req.value;
            den_nxt   = in_req.modulus;
            dsh_nxt   = in_req.modulus;
            cnt_nxt   = '0;
            acc_nxt   = '0;
            red_nxt   = 1'b1;
            state_nxt = ST_ALIGN;
          end
        end
      end
      ST_ALIGN: begin
        if (align_go) begin
          dsh_nxt = {dsh_r[WIDTH-2:0], 1'b0};
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          state_nxt = ST_SUB;
        end
      end
      ST_SUB: begin
        if (sub_ge) begin
          num_nxt = num_r - dsh_r;
        end
        acc_nxt = macc_res;
        if (cnt_r == '0) begin
          state_nxt = ST_NEXT;
        end else begin
          dsh_nxt = {1'b0, dsh_r[WIDTH-1:1]};
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      ST_NEXT: begin
        cnt_nxt = '0;
        acc_nxt = '0;
        if (red_r) begin
          red_nxt = 1'b0;
          t0_nxt  = '0;
          t1_nxt  = WIDTH'(1);
          if (num_r == '0) begin
            res_inv_nxt = '0;
            res_ok_nxt  = 1'b0;
            state_nxt   = ST_FIN;
          end else begin
            num_nxt   = mod_r;
            den_nxt   = num_r;
            dsh_nxt   = num_r;
            state_nxt = ST_ALIGN;
          end
        end else begin
          t0_nxt = t1_r;
          t1_nxt = t_new;
          if (num_r == '0) begin
            res_ok_nxt  = (den_r == WIDTH'(1));
            res_inv_nxt = (den_r == WIDTH'(1)) ? t1_r : '0;
            state_nxt   = ST_FIN;
          end else begin
            num_nxt   = den_r;
            den_nxt   = num_r;
            dsh_nxt   = num_r;
            state_nxt = ST_ALIGN;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_inv_nxt   = res_inv_r;
          out_ok_nxt    = res_ok_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    dsh_r     <= dsh_nxt;
    cnt_r     <= cnt_nxt;
    t0_r      <= t0_nxt;
    t1_r      <= t1_nxt;
    acc_r     <= acc_nxt;
    mod_r     <= mod_nxt;
    red_r     <= red_nxt;
    res_inv_r <= res_inv_nxt;
    res_ok_r  <= res_ok_nxt;
    out_inv_r <= out_inv_nxt;
    out_ok_r  <= out_ok_nxt;
  end

  a_small_modulus: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_req.modulus < WIDTH'(2)) |=> (state_r == ST_FIN) && !res_ok_r)
    else $error("small modulus did not go straight to the result");

  a_no_inverse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok_r |-> (out_inv_r == '0))
    else $error("inverse nonzero without a valid inverse");

  a_inverse_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && res_ok_r |-> (res_inv_r < mod_r))
    else $error("inverse not below the modulus");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUB) || (state_r == ST_ALIGN) |-> (dsh_r != '0))
    else $error("division with a zero divisor");

  a_coeff_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUB) && !red_r |-> (t1_r < mod_r) && (acc_r < mod_r))
    else $error("coefficient left the residue range");

endmodule

[verif/tb_top.sv]
// Testbench for the modular inverse block: directed table, then random requests against a predictor.
module tb_top;

  typedef struct {
    logic [15:0] value;
    logic [15:0] modulus;
    logic [15:0] inverse;
    logic        has_inverse;
  } inv_request_t;

  typedef struct {
    logic [15:0] value;
    logic [15:0] modulus;
    logic [15:0] inverse;
    logic        has_inverse;
    bit          known;
  } dir_row_t;

  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PER_PHASE = 160;
  localparam int DRAIN_CYCLES = 200;

  logic clk;
  logic rst_n;

  modinv_in_if #(.WIDTH(16))  req_if ();
  modinv_out_if #(.WIDTH(16)) rsp_if ();

  modular_inverse #(.WIDTH(16)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  inv_request_t pending_inverses[$];
  inv_request_t oldest;
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           hold_req_count = 0;

  dir_row_t dir_rows [23] = '{
    '{16'd5,     16'd0,     16'd0,     1'b0, 1'b1},
    '{16'd65535, 16'd0,     16'd0,     1'b0, 1'b1},
    '{16'd7,     16'd1,     16'd0,     1'b0, 1'b1},
    '{16'd65535, 16'd1,     16'd0,     1'b0, 1'b1},
    '{16'd1,     16'd2,     16'd1,     1'b1, 1'b1},
    '{16'd65535, 16'd2,     16'd1,     1'b1, 1'b1},
    '{16'd0,     16'd7,     16'd0,     1'b0, 1'b1},
    '{16'd14,    16'd7,     16'd0,     1'b0, 1'b1},
    '{16'd0,     16'd65535, 16'd0,     1'b0, 1'b1},
    '{16'd65535, 16'd65535, 16'd0,     1'b0, 1'b1},
    '{16'd1,     16'd65535, 16'd1,     1'b1, 1'b1},
    '{16'd65534, 16'd65535, 16'd65534, 1'b1, 1'b1},
    '{16'd65535, 16'd65534, 16'd1,     1'b1, 1'b1},
    '{16'd32768, 16'd32769, 16'd32768, 1'b1, 1'b1},
    '{16'd2,     16'd65535, 16'd32768, 1'b1, 1'b1},
    '{16'd3,     16'd7,     16'd5,     1'b1, 1'b1},
    '{16'd6,     16'd9,     16'd0,     1'b0, 1'b1},
    '{16'hAAAA,  16'h5555,  16'd0,     1'b0, 1'b1},
    '{16'h5555,  16'hAAAA,  16'd0,     1'b0, 1'b0},
    '{16'd28657, 16'd46368, 16'd0,     1'b0, 1'b0},
    '{16'd12345, 16'd65521, 16'd0,     1'b0, 1'b0},
    '{16'd65535, 16'd65521, 16'd0,     1'b0, 1'b0},
    '{16'd46368, 16'd28657, 16'd0,     1'b0, 1'b0}
  };

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic inv_request_t predict_inverse(logic [15:0] v, logic [15:0] m);
    bit [31:0] r0, r1, r2, q, t0, t1, t2, prod, mw;
    inv_request_t p;
    p.value = v;
    p.modulus = m;
    p.inverse = 16'd0;
    p.has_inverse = 1'b0;
    if (m >= 16'd2) begin
      mw = {16'd0, m};
      r0 = mw;
      r1 = {16'd0, v} % mw;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
        q = r0 / r1;
        r2 = r0 - q * r1;
        prod = ((q % mw) * t1) % mw;
        t2 = (t0 >= prod) ? t0 - prod : t0 + mw - prod;
        r0 = r1;
        r1 = r2;
        t0 = t1;
        t1 = t2;
      end
      if (r0 == 1) begin
        p.inverse = t0[15:0];
        p.has_inverse = 1'b1;
      end
    end
    return p;
  endfunction

  task automatic pick_operands(output logic [15:0] v, output logic [15:0] m);
    int kind;
    int k;
    int fa, fb, fc;
    logic [15:0] primes [6] = '{16'd65521, 16'd65519, 16'd251, 16'd257, 16'd7, 16'd3};
    kind = $urandom_range(9);
    v = 16'($urandom_range(65535));
    m = 16'($urandom_range(65535));
    case (kind)
      0, 1, 2, 3: begin
      end
      4: begin
        m = 16'($urandom_range(64, 2));
      end
      5, 6: begin
        m = primes[$urandom_range(5)];
      end
      7: begin
        m = 16'($urandom_range(300, 2));
        v = 16'(m * $urandom_range(65535 / m));
      end
      8: begin
        m = 16'($urandom_range(1));
      end
      default: begin
        k = $urandom_range(22, 2);
        fa = 1;
        fb = 1;
        repeat (k) begin
          fc = fa + fb;
          fa = fb;
          fb = fc;
        end
        if ($urandom_range(1)) begin
          v = 16'(fa);
          m = 16'(fb);
        end else begin
          v = 16'(fb);
          m = 16'(fa);
        end
      end
    endcase
  endtask

  task automatic send_req(input inv_request_t expected);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.value <= expected.value;
    req_if.modulus <= expected.modulus;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_inverses = {pending_inverses, expected};
  endtask

  task automatic report_mismatch(input string what, input inv_request_t expected);
    $display("MISMATCH %s: value=%0d modulus=%0d got inverse=%0d flag=%0b, expected %0d/%0b",
             what, expected.value, expected.modulus, rsp_if.inverse, rsp_if.has_inverse,
             expected.inverse, expected.has_inverse);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_inverses.size() == 0) begin
        oldest = '{default: '0};
        report_mismatch("result with no request pending", oldest);
      end else begin
        oldest = pending_inverses.pop_front();
        if (rsp_if.inverse !== oldest.inverse) report_mismatch("inverse", oldest);
        if (rsp_if.has_inverse !== oldest.has_inverse) report_mismatch("has_inverse", oldest);
      end
    end
  end

  initial begin
    int holds_done;
    holds_done = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done < hold_req_count) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    logic [15:0] v;
    logic [15:0] m;
    inv_request_t expected;
    req_if.valid <= 1'b0;
    req_if.value <= '0;
    req_if.modulus <= '0;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 24;
    recv_idle_pct = 80;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].known) begin
        expected.value = dir_rows[i].value;
        expected.modulus = dir_rows[i].modulus;
        expected.inverse = dir_rows[i].inverse;
        expected.has_inverse = dir_rows[i].has_inverse;
      end else begin
        expected = predict_inverse(dir_rows[i].value, dir_rows[i].modulus);
      end
      send_req(expected);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 80 : 0;
      recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 24 : 0;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (phase == 0 && i == 40) hold_req_count++;
        if (phase == 1 && i == 80) begin
          req_if.valid <= 1'b0;
          while (pending_inverses.size() != 0) @(posedge clk);
          @(posedge clk);
        end
        pick_operands(v, m);
        send_req(predict_inverse(v, m));
      end
    end

    req_if.valid <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
